// ===== hw/rtl/tdpt_pkg.sv =====
// Shared types and constants for the trial-division prime test core.
// No dependencies.
package tdpt_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_FINISH
    } state_t;

    localparam int SMALLEST_PRIME = 2;
    localparam int FIRST_DIVISOR  = 3;
    localparam int DIVISOR_STEP   = 2;

endpackage

// ===== hw/rtl/trial_division_prime_test_core.sv =====
// Top level of the trial-division prime test: sequencer, odd-divisor counter
// and output register. Depends on tdpt_pkg and tdpt_divider.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------
//  input   | in_valid / in_stall  | candidate [VALUE_WIDTH-1:0], signed
//  output  | out_valid / out_stall| is_prime
//
// Negative, 0, 1, 2 and even values finish without any division. Each odd
// divisor tried costs one pass of the bit-serial divider; the worst case
// is about sqrt(2^(VALUE_WIDTH-1))/2 divisors.
// One item is in work at a time; in_stall is high until its result is moved
// into the output register, which holds it while out_stall is high.
// Reset clears the sequencer and output valid; no other state is kept.
module trial_division_prime_test_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [VALUE_WIDTH-1:0] candidate,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   is_prime
);

    localparam int N = VALUE_WIDTH - 1;

    tdpt_pkg::state_t state_reg, state_next;

    logic [N-1:0] n_reg, n_next;
    logic [N-1:0] d_reg, d_next;
    logic         res_reg, res_next;
    logic         out_valid_reg, out_valid_next;
    logic         is_prime_reg, is_prime_next;

    logic         accept;
    logic         out_free;
    logic         div_start;
    logic         div_done;
    logic [N-1:0] div_quo;
    logic [N-1:0] div_rem;
    logic [N-1:0] cand_mag;
    logic         cand_neg;
    logic         trivial;
    logic         trivial_res;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign cand_mag = candidate[N-1:0];
    assign cand_neg = candidate[N];

    // cases settled without any division
    always_comb
    begin
        trivial     = 1'b1;
        trivial_res = 1'b0;
        if (cand_neg || cand_mag[N-1:1] == '0)
        begin
            trivial_res = 1'b0;
        end
        else if (cand_mag == N'(tdpt_pkg::SMALLEST_PRIME))
        begin
            trivial_res = 1'b1;
        end
        else if (!cand_mag[0])
        begin
            trivial_res = 1'b0;
        end
        else
        begin
            trivial = 1'b0;
        end
    end

    tdpt_divider #(
        .N(N)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tdpt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = trivial ? tdpt_pkg::ST_FINISH : tdpt_pkg::ST_START;
                end
            end
            tdpt_pkg::ST_START:
            begin
                state_next = tdpt_pkg::ST_DIV;
            end
            tdpt_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    // d > n/d means d*d > n: no divisor left to try
                    if (d_reg > div_quo || div_rem == '0)
                    begin
                        state_next = tdpt_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = tdpt_pkg::ST_START;
                    end
                end
            end
            tdpt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = tdpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath next values
    always_comb
    begin
        in_stall       = 1'b1;
        div_start      = 1'b0;
        n_next         = n_reg;
        d_next         = d_reg;
        res_next       = res_reg;
        is_prime_next  = is_prime_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            tdpt_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (accept)
                begin
                    n_next   = cand_mag;
                    d_next   = N'(tdpt_pkg::FIRST_DIVISOR);
                    res_next = trivial_res;
                end
            end
            tdpt_pkg::ST_START:
            begin
                div_start = 1'b1;
            end
            tdpt_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    if (d_reg > div_quo)
                    begin
                        res_next = 1'b1;
                    end
                    else if (div_rem == '0)
                    begin
                        res_next = 1'b0;
                    end
                    else
                    begin
                        d_next = d_reg + N'(tdpt_pkg::DIVISOR_STEP);
                    end
                end
            end
            tdpt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = res_reg;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdpt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        d_reg        <= d_next;
        res_reg      <= res_next;
        is_prime_reg <= is_prime_next;
    end

    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

`ifndef SYNTHESIS
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == tdpt_pkg::ST_DIV)
        else $error("divider finished outside the divide state");

    a_divisor_odd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tdpt_pkg::ST_DIV |-> d_reg[0])
        else $error("trial divisor is even");

    a_divisor_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tdpt_pkg::ST_DIV && !div_done) |=> $stable(d_reg) && $stable(n_reg))
        else $error("operands changed during a division");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tdpt_pkg::ST_FINISH && out_free) |=> out_valid && is_prime == $past(res_reg))
        else $error("result not moved to the output register");
`endif

endmodule

// ===== hw/rtl/tdpt_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on nothing; instantiated by trial_division_prime_test_core.
module tdpt_divider #(
    parameter int N = 31
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [N-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient,
    output logic [N-1:0] remainder
);

    localparam int CNT_W = $clog2(N + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [N-1:0]     rem_reg, rem_next;
    logic [N-1:0]     quo_reg, quo_next;
    logic [N:0]       trial;
    logic [N:0]       diff;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[N-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CNT_W'(N);
            rem_next = '0;
            quo_next = dividend;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
            if (!diff[N])
            begin
                rem_next = diff[N-1:0];
                quo_next = {quo_reg[N-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[N-1:0];
                quo_next = {quo_reg[N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== bench/trial_division_prime_test_core_tb.sv =====
// Testbench for trial_division_prime_test_core: directed and random candidates are
// checked against a behavioral primality predictor, with random input gaps and output stalls.
// Depends on tdpt_pkg and the core's RTL.
module trial_division_prime_test_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_WIDTH      = 32;
    localparam int QUIET_TAIL       = 15;
    localparam int LONG_HOLD_AT     = 40;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int RANDOM_ITEMS     = 80;

    typedef struct {
        logic [VALUE_WIDTH-1:0] value;
        logic                   verdict;
    } verdict_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [VALUE_WIDTH-1:0] candidate = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   is_prime;

    logic [VALUE_WIDTH-1:0] candidates_pending[$];
    verdict_t               verdicts_due[$];
    verdict_t               due;
    int                     n_items;
    int                     n_directed;
    int                     n_errors;

    // sender bookkeeping
    int   n_sent;
    int   n_answered_tx;
    int   gap_left;
    logic offer_next;

    // receiver bookkeeping
    int   n_answered_rx;
    int   hold_left;
    int   long_hold_left;
    logic long_hold_done;

    trial_division_prime_test_core #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .candidate (candidate),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime)
    );

    function automatic logic prime_verdict(logic [VALUE_WIDTH-1:0] value);
        longint unsigned n;
        longint unsigned d;
        if (value[VALUE_WIDTH-1])
            return 1'b0;
        n = value;
        if (n < tdpt_pkg::SMALLEST_PRIME)
            return 1'b0;
        if (n == tdpt_pkg::SMALLEST_PRIME)
            return 1'b1;
        if (n[0] == 1'b0)
            return 1'b0;
        for (d = tdpt_pkg::FIRST_DIVISOR; d <= n / d; d += tdpt_pkg::DIVISOR_STEP)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sender: one nonblocking write of in_valid per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            candidate     <= '0;
            n_sent        = 0;
            n_answered_tx = 0;
            gap_left      = 0;
        end
        else
        begin
            offer_next = in_valid;
            if (out_valid && !out_stall)
                n_answered_tx++;
            if (in_valid && !in_stall)
            begin
                verdicts_due.push_back('{value: candidate, verdict: prime_verdict(candidate)});
                n_sent++;
                offer_next = 1'b0;
            end
            if (!offer_next && candidates_pending.size() != 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (n_sent == n_directed && n_answered_tx != n_sent)
                    ; // hold off until the directed part has fully drained
                else if (candidates_pending.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(0, 3);
                else
                begin
                    candidate  <= candidates_pending.pop_front();
                    offer_next = 1'b1;
                end
            end
            in_valid <= offer_next;
        end
    end

    // Receiver stall: random short bursts plus one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall      <= 1'b0;
            n_answered_rx  = 0;
            hold_left      = 0;
            long_hold_left = 0;
            long_hold_done = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                n_answered_rx++;
            if (!long_hold_done && n_answered_rx >= LONG_HOLD_AT)
            begin
                long_hold_left = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (n_answered_rx < n_items - QUIET_TAIL && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, got is_prime %0b",
                         $time, is_prime);
                n_errors++;
            end
            else
            begin
                due = verdicts_due.pop_front();
                if (is_prime !== due.verdict)
                begin
                    $display("%0t: candidate %0d: expected is_prime %0b, got %0b",
                             $time, $signed(due.value), due.verdict, is_prime);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        n_errors = 0;
        // sign and range extremes, small values, squares of primes, large composites
        candidates_pending = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25,
            32'd97, 32'd60491, 32'd63001, 32'd65521,
            32'hFFFF_FFFF, 32'h8000_0000, -32'sd7,
            32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h5555_5555, 32'h2AAA_AAAA,
            32'h7FFF_FFFF
        };
        n_directed = candidates_pending.size();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            case ($urandom_range(0, 19))
                0, 1:    candidates_pending.push_back($urandom | 32'h8000_0000);
                2, 3:    candidates_pending.push_back($urandom & 32'h7FFF_FFFE);
                4:       candidates_pending.push_back(3 * ($urandom_range(1, 715827881) | 1));
                5, 6, 7: candidates_pending.push_back($urandom_range(4096, 65535));
                default: candidates_pending.push_back($urandom_range(0, 4095));
            endcase
        end
        n_items = candidates_pending.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // every item sent must come back before the run closes
        while (n_answered_rx < n_items)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (n_errors == 0 && verdicts_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #150_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
